// ===== rtl/nsr_pkg.sv =====
package nsr_pkg;

  // Fixed field widths
  localparam int DATA_W     = 32;  // radicand, tolerance, iterate x
  localparam int ROOT_W     = 24;
  localparam int LIMIT_W    = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int S_TDATA_W  = 32;
  localparam int M_TDATA_W  = 32;
  localparam int PROD_W     = 2 * DATA_W;

  localparam int FRACTION_BITS_DEF = 16;

  localparam logic [DATA_W-1:0]  TOL_RESET   = 32'd42950;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT     = 1'd1;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_BOUND = 7'b0000010,
    S_DIV   = 7'b0000100,
    S_UPD   = 7'b0001000,
    S_SQR   = 7'b0010000,
    S_CMP   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_e;

endpackage

// ===== rtl/nsr_div.sv =====
// Restoring divider, one quotient bit per cycle.
module nsr_div #(
  parameter int DIVIDEND_W = nsr_pkg::DATA_W - 1 + nsr_pkg::FRACTION_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [DIVIDEND_W-1:0]         dividend_i,
  input  logic [nsr_pkg::DATA_W-1:0]    divisor_i,
  output logic                          done_o,
  output logic [DIVIDEND_W-1:0]         quotient_o
);
  import nsr_pkg::*;

  localparam int CW = $clog2(DIVIDEND_W + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [DATA_W-1:0] rem_q, rem_d;
  logic [DATA_W-1:0] dvs_q, dvs_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;
  logic              ge;

  assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(DIVIDEND_W);
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      quo_d = {quo_q[DIVIDEND_W-2:0], ge};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== rtl/nsr_mul.sv =====
// Shift-add multiplier, one multiplier bit per cycle.
module nsr_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [nsr_pkg::DATA_W-1:0]    a_i,
  input  logic [nsr_pkg::DATA_W-1:0]    b_i,
  output logic                          done_o,
  output logic [nsr_pkg::PROD_W-1:0]    prod_o
);
  import nsr_pkg::*;

  localparam int CW = $clog2(DATA_W + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [DATA_W-1:0] a_q, a_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [DATA_W:0]   sum;

  assign sum = {1'b0, prod_q[PROD_W-1:DATA_W]} + (prod_q[0] ? {1'b0, a_q} : '0);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    prod_d = prod_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(DATA_W);
      a_d    = a_i;
      prod_d = {{DATA_W{1'b0}}, b_i};
    end else if (busy_q) begin
      prod_d = {sum, prod_q[DATA_W-1:1]};
      cnt_d  = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    prod_q <= prod_d;
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule

// ===== rtl/newton_square_root.sv =====
// Newton-Raphson square root, signed fixed-point radicand in, unsigned root out.
//
// Input stream s_axis: one radicand per item (signed, FRACTION_BITS fraction bits).
// Output stream m_axis: root, negative_input and limit_reached per item.
// Config port: cfg_we_i writes cfg_data_i to register cfg_index_i
// (0: relative tolerance Q0.32, 1: iteration limit); write only while idle.
//
// One item is in flight at a time. A negative or zero radicand goes from
// acceptance straight to the output state. Otherwise the block first forms the
// tolerance bound (serial multiplier), then per Newton step runs the
// bit-serial divider, an update state, the serial squaring and a compare
// state; the number of steps is bounded by the iteration limit (0 acts as 1).
// Input reopens in the same cycle that the result enters the output register.
// The result sits in an output register; a new item is accepted while it
// waits for m_axis_tready. If the receiver stalls the finished result waits
// in the core until the output register frees up, and input stays blocked.
// Reset clears the control state and restores the default register values.
module newton_square_root #(
  parameter int FRACTION_BITS = nsr_pkg::FRACTION_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // [31:0] radicand
  input  logic [nsr_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [23:0] root, [24] negative_input, [25] limit_reached, [31:26] zero
  output logic [nsr_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic                              cfg_we_i,
  input  logic [nsr_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [nsr_pkg::DATA_W-1:0]        cfg_data_i
);
  import nsr_pkg::*;

  localparam int NW = DATA_W - 1 + FRACTION_BITS;  // scaled radicand width
  localparam int BW = DATA_W + FRACTION_BITS;      // tolerance bound width
  localparam logic [DATA_W-1:0] X_ONE = DATA_W'(1) << FRACTION_BITS;

  state_e state_q, state_d;

  logic [DATA_W-1:0]  tol_q, tol_d;
  logic [LIMIT_W-1:0] lim_q, lim_d;
  logic [LIMIT_W-1:0] lim_eff;

  logic [DATA_W-2:0]  rad_q, rad_d;
  logic [DATA_W-1:0]  x_q, x_d;
  logic [LIMIT_W-1:0] steps_q, steps_d;
  logic [BW-1:0]      bound_q, bound_d;
  logic [PROD_W-1:0]  err_q, err_d;
  logic [ROOT_W-1:0]  res_root_q, res_root_d;
  logic               res_neg_q, res_neg_d;
  logic               res_hit_q, res_hit_d;

  logic               m_valid_q, m_valid_d;
  logic [ROOT_W-1:0]  out_root_q, out_root_d;
  logic               out_neg_q, out_neg_d;
  logic               out_hit_q, out_hit_d;

  logic               s_fire, in_neg, in_zero;
  logic [NW-1:0]      big_n;
  logic [PROD_W-1:0]  big_n_ext;

  logic               mul_start, mul_done;
  logic [DATA_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0]  mul_prod;
  logic               div_start, div_done;
  logic [NW-1:0]      div_quo;

  logic [NW:0]        nx_sum;
  logic [NW-1:0]      nx;
  logic [DATA_W-1:0]  nx_sat;
  logic               met;
  logic [ROOT_W-1:0]  root_sat;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign in_neg        = s_axis_tdata[DATA_W-1];
  assign in_zero       = (s_axis_tdata == '0);

  assign big_n     = {rad_q, {FRACTION_BITS{1'b0}}};
  assign big_n_ext = PROD_W'(big_n);
  assign lim_eff   = (lim_q == '0) ? LIMIT_W'(1) : lim_q;

  // x' = (x + N/x) / 2, kept within 1 .. 2^32-1
  assign nx_sum = {1'b0, div_quo} + (NW+1)'(x_q);
  assign nx     = nx_sum[NW:1];
  always_comb begin
    if (|nx[NW-1:DATA_W]) begin
      nx_sat = '1;
    end else if (nx[DATA_W-1:0] == '0) begin
      nx_sat = DATA_W'(1);
    end else begin
      nx_sat = nx[DATA_W-1:0];
    end
  end

  assign met      = (err_q <= PROD_W'(bound_q));
  assign root_sat = (|x_q[DATA_W-1:ROOT_W]) ? '1 : x_q[ROOT_W-1:0];

  // Multiplier serves the bound tol*n at start, then x*x every step
  assign mul_start = (s_fire && !in_neg && !in_zero) || (state_q == S_UPD);
  assign mul_a     = (state_q == S_IDLE) ? tol_q : nx_sat;
  assign mul_b     = (state_q == S_IDLE) ? {1'b0, s_axis_tdata[DATA_W-2:0]} : nx_sat;

  always_comb begin
    state_d    = state_q;
    tol_d      = tol_q;
    lim_d      = lim_q;
    rad_d      = rad_q;
    x_d        = x_q;
    steps_d    = steps_q;
    bound_d    = bound_q;
    err_d      = err_q;
    res_root_d = res_root_q;
    res_neg_d  = res_neg_q;
    res_hit_d  = res_hit_q;
    m_valid_d  = m_valid_q;
    out_root_d = out_root_q;
    out_neg_d  = out_neg_q;
    out_hit_d  = out_hit_q;
    div_start  = 1'b0;

    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_TOLERANCE: tol_d = cfg_data_i;
        REG_LIMIT:     lim_d = cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          rad_d      = s_axis_tdata[DATA_W-2:0];
          x_d        = X_ONE;
          steps_d    = '0;
          res_root_d = '0;
          res_neg_d  = in_neg;
          res_hit_d  = 1'b0;
          state_d    = (in_neg || in_zero) ? S_OUT : S_BOUND;
        end
      end
      S_BOUND: begin
        if (mul_done) begin
          bound_d   = mul_prod[PROD_W-1:DATA_W-FRACTION_BITS];
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        x_d     = nx_sat;
        steps_d = steps_q + LIMIT_W'(1);
        state_d = S_SQR;
      end
      S_SQR: begin
        if (mul_done) begin
          err_d   = (mul_prod >= big_n_ext) ? (mul_prod - big_n_ext)
                                            : (big_n_ext - mul_prod);
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (met || (steps_q >= lim_eff)) begin
          res_root_d = root_sat;
          res_hit_d  = !met;
          state_d    = S_OUT;
        end else begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d  = 1'b1;
          out_root_d = res_root_q;
          out_neg_d  = res_neg_q;
          out_hit_d  = res_hit_q;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      tol_q     <= TOL_RESET;
      lim_q     <= LIMIT_RESET;
      steps_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      tol_q     <= tol_d;
      lim_q     <= lim_d;
      steps_q   <= steps_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q      <= rad_d;
    x_q        <= x_d;
    bound_q    <= bound_d;
    err_q      <= err_d;
    res_root_q <= res_root_d;
    res_neg_q  <= res_neg_d;
    res_hit_q  <= res_hit_d;
    out_root_q <= out_root_d;
    out_neg_q  <= out_neg_d;
    out_hit_q  <= out_hit_d;
  end

  nsr_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  nsr_div #(
    .DIVIDEND_W (NW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (big_n),
    .divisor_i  (x_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = M_TDATA_W'({out_hit_q, out_neg_q, out_root_q});

endmodule

// ===== rtl/nsr_checker.sv =====
module nsr_props (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [nsr_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import nsr_pkg::*;

  // one item at a time: input closes right after an accept
  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while an item is in flight");

  // negative radicand gives a zero root and no limit flag
  a_neg_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[ROOT_W] |->
      (m_axis_tdata[ROOT_W-1:0] == '0) && !m_axis_tdata[ROOT_W+1])
    else $error("negative radicand with nonzero root or limit flag");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or dropped");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[M_TDATA_W-1:ROOT_W+2] == '0))
    else $error("output padding bits not zero");

endmodule

bind newton_square_root nsr_props u_nsr_props (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
